// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tpcm_pkg.sv -----
// shared types and constants for the temperature to pwm compare map
// no dependencies
package tpcm_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    // divide by ten: x / 10 == (x * 52429) >> 19 for x below 43690
    localparam logic [15:0] RECIP10 = 16'd52429;
    localparam int RECIP10_SHIFT = 19;

    localparam int NUM_W = 24;
    localparam int DIV_STEP = 4;
    localparam int DIV_STAGES = NUM_W / DIV_STEP;

    localparam logic [15:0] TOP_COUNT_RST = 16'd2500;

    localparam logic [1:0] CFG_TOP_COUNT = 2'd0;
    localparam logic [1:0] CFG_LOW_LIMIT = 2'd1;
    localparam logic [1:0] CFG_HIGH_LIMIT = 2'd2;

    typedef struct packed {
        logic [15:0] top_count;
        logic [7:0]  low_limit;
        logic [7:0]  high_limit;
    } t_cfg;

    typedef struct packed {
        logic             need_div;
        logic [15:0]      value;
        logic [NUM_W-1:0] num;
        logic [7:0]       den;
    } t_entry;

endpackage

// ----- rtl/temperature_to_pwm_compare_map.sv -----
// top level: configuration registers, front end, queue and divider back end
// uses tpcm_pkg, tpcm_front, tpcm_queue and tpcm_back
//
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_stall     i_temp_tenths, i_out_of_range
// output    out        o_out_valid / i_out_stall   o_compare_value
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// one transaction per cycle sustained while the output does not stall; the path runs
// through 4 front stages, the queue, a register taking the queue head, DIV_STAGES
// divider stages and the output register
// the divider back end is pipelined at four quotient bits per stage
// reset clears all valid bits and the queue and loads the register reset values
// an output stall freezes the back end; the front end keeps filling the queue
// and stalls the input only once its last stage holds and the queue is full
module temperature_to_pwm_compare_map #(
    parameter int QUEUE_DEPTH = tpcm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_temp_tenths,
    input  logic               i_out_of_range,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_compare_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import tpcm_pkg::*;

    t_cfg   r_cfg;
    t_entry front_entry;
    t_entry q_head;
    logic   front_push;
    logic   q_full, q_empty, q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.top_count <= TOP_COUNT_RST;
            r_cfg.low_limit <= '0;
            r_cfg.high_limit <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TOP_COUNT:  r_cfg.top_count <= i_cfg_data;
                CFG_LOW_LIMIT:  r_cfg.low_limit <= i_cfg_data[7:0];
                CFG_HIGH_LIMIT: r_cfg.high_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    tpcm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_temp_tenths  (i_temp_tenths),
        .i_out_of_range (i_out_of_range),
        .i_q_full       (q_full),
        .o_push         (front_push),
        .o_entry        (front_entry)
    );

    tpcm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    tpcm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_compare_value (o_compare_value)
    );

endmodule

// ----- rtl/tpcm_front.sv -----
// front end: accepts samples, scales to whole degrees and classifies them
// uses tpcm_pkg and assert_macros.svh
`include "assert_macros.svh"
module tpcm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tpcm_pkg::t_cfg        i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [15:0]    i_temp_tenths,
    input  logic                  i_out_of_range,
    input  logic                  i_q_full,
    output logic                  o_push,
    output tpcm_pkg::t_entry      o_entry
);
    import tpcm_pkg::*;

    logic        f_en;
    logic        r_v1, r_v2, r_v3, r_v4;
    logic [15:0] r_abs1;
    logic        r_neg1, r_alarm1;
    logic [31:0] r_prod2;
    logic        r_neg2, r_alarm2;
    t_entry      r_e3;
    logic [15:0] r_delta3;
    logic [7:0]  r_diff3;
    t_entry      r_e4;
    logic [15:0] n_abs1;
    t_entry      n_e3;
    logic [15:0] n_delta3;
    logic [7:0]  n_diff3;
    t_entry      n_e4;

    assign f_en = !r_v4 || !i_q_full;
    assign o_in_stall = !f_en;
    assign o_push = r_v4 && !i_q_full;
    assign o_entry = r_e4;

    assign n_abs1 = i_temp_tenths[15] ? 16'(-i_temp_tenths) : 16'(i_temp_tenths);

    always_comb begin
        logic [12:0]        v_q;
        logic signed [12:0] v_t;
        logic signed [12:0] v_lo;
        logic signed [12:0] v_hi;
        logic [15:0]        v_top;
        logic [15:0]        v_half;
        v_q = r_prod2[31:RECIP10_SHIFT];
        v_t = r_neg2 ? -$signed(v_q) : $signed(v_q);
        v_lo = $signed({5'b0, i_cfg.low_limit});
        v_hi = $signed({5'b0, i_cfg.high_limit});
        v_top = i_cfg.top_count;
        v_half = {1'b0, v_top[15:1]};
        n_e3 = '0;
        n_delta3 = v_top - v_half;
        n_diff3 = 8'(v_t - v_lo);
        n_e3.den = i_cfg.high_limit - i_cfg.low_limit;
        if (r_alarm2) begin
            n_e3.value = v_top;
        end else if (i_cfg.high_limit == i_cfg.low_limit) begin
            n_e3.value = 16'(({1'b0, v_top} + {1'b0, v_half}) >> 1);
        end else if (v_t <= v_lo) begin
            n_e3.value = v_top;
        end else if (v_t >= v_hi) begin
            n_e3.value = v_half;
        end else begin
            n_e3.value = v_top;
            n_e3.need_div = 1'b1;
        end
    end

    always_comb begin
        n_e4 = r_e3;
        n_e4.num = NUM_W'(r_delta3) * NUM_W'(r_diff3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (f_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_abs1 <= n_abs1;
            r_neg1 <= i_temp_tenths[15];
            r_alarm1 <= i_out_of_range;
            r_prod2 <= 32'(r_abs1) * 32'(RECIP10);
            r_neg2 <= r_neg1;
            r_alarm2 <= r_alarm1;
            r_e3 <= n_e3;
            r_delta3 <= n_delta3;
            r_diff3 <= n_diff3;
            r_e4 <= n_e4;
        end
    end

    // quotient must fit sixteen bits and the divisor be non-zero
    `ASSERT_ALWAYS(a_div_operands, i_clk, i_rst_n, (r_v4 && r_e4.need_div) |-> (r_e4.den != 8'd0 && r_e4.num[23:16] < r_e4.den), "divide operands out of range")

endmodule

// ----- rtl/tpcm_queue.sv -----
// small register queue between front end and divider back end
// uses tpcm_pkg and assert_macros.svh
`include "assert_macros.svh"
module tpcm_queue #(
    parameter int QUEUE_DEPTH = tpcm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tpcm_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output tpcm_pkg::t_entry o_head
);
    import tpcm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
    `ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, do_push && !do_pop, !o_empty, "pushed transaction lost")

endmodule

// ----- rtl/tpcm_back.sv -----
// back end: pipelined restoring divider and final compare value register
// uses tpcm_pkg and assert_macros.svh
`include "assert_macros.svh"
module tpcm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  tpcm_pkg::t_entry i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [15:0]      o_compare_value
);
    import tpcm_pkg::*;

    logic             b_en;
    logic             r_bv   [DIV_STAGES+1];
    logic [7:0]       r_rem  [DIV_STAGES+1];
    logic [NUM_W-1:0] r_dq   [DIV_STAGES+1];
    logic [7:0]       r_den  [DIV_STAGES+1];
    logic [15:0]      r_base [DIV_STAGES+1];
    logic             r_need [DIV_STAGES+1];
    logic [7:0]       n_rem  [DIV_STAGES];
    logic [NUM_W-1:0] n_dq   [DIV_STAGES];
    logic             r_out_valid;
    logic [15:0]      r_out;

    assign b_en = !r_out_valid || !i_out_stall;
    assign o_pop = b_en && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_compare_value = r_out;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        always_comb begin
            logic [8:0]       v_try;
            logic [7:0]       v_rem;
            logic [NUM_W-1:0] v_dq;
            v_rem = r_rem[s];
            v_dq = r_dq[s];
            for (int k = 0; k < DIV_STEP; k++) begin
                v_try = {v_rem, v_dq[NUM_W-1]};
                v_dq = {v_dq[NUM_W-2:0], 1'b0};
                if (v_try >= {1'b0, r_den[s]}) begin
                    v_try = v_try - {1'b0, r_den[s]};
                    v_dq[0] = 1'b1;
                end
                v_rem = v_try[7:0];
            end
            n_rem[s] = v_rem;
            n_dq[s] = v_dq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                r_bv[s] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (b_en) begin
            r_bv[0] <= !i_q_empty;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_bv[s+1] <= r_bv[s];
            end
            r_out_valid <= r_bv[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_rem[0] <= '0;
            r_dq[0] <= i_head.num;
            r_den[0] <= i_head.den;
            r_base[0] <= i_head.value;
            r_need[0] <= i_head.need_div;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s+1] <= n_rem[s];
                r_dq[s+1] <= n_dq[s];
                r_den[s+1] <= r_den[s];
                r_base[s+1] <= r_base[s];
                r_need[s+1] <= r_need[s];
            end
            r_out <= r_need[DIV_STAGES] ? r_base[DIV_STAGES] - r_dq[DIV_STAGES][15:0]
                                        : r_base[DIV_STAGES];
        end
    end

    // interpolated step never exceeds the top count
    `ASSERT_ALWAYS(a_quot_range, i_clk, i_rst_n, (r_bv[DIV_STAGES] && r_need[DIV_STAGES]) |-> (r_dq[DIV_STAGES][23:16] == 8'd0 && r_dq[DIV_STAGES][15:0] <= r_base[DIV_STAGES]), "quotient out of range")

endmodule

// ----- verif/tb_temperature_to_pwm_compare_map.sv -----
`timescale 1ns / 1ps
// self-checking testbench for temperature_to_pwm_compare_map: directed table then random phases
// depends on tpcm_pkg and the rtl of temperature_to_pwm_compare_map
module tb_temperature_to_pwm_compare_map;
    import tpcm_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 24;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  index;
        logic [15:0] data;
        logic        alarm;
        logic        has_value;
        logic [15:0] value;
    } t_row;

    localparam int NUM_ROWS = 40;
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        // register values straight after reset, limits equal
        '{ROW_ITEM, 2'd0, 16'd0,      1'b0, 1'b1, 16'd1875},
        '{ROW_ITEM, 2'd0, 16'h7FFF,   1'b1, 1'b1, 16'd2500},
        '{ROW_CFG,  CFG_LOW_LIMIT,  16'd20, 1'b0, 1'b0, 16'd0},
        '{ROW_CFG,  CFG_HIGH_LIMIT, 16'd30, 1'b0, 1'b0, 16'd0},
        '{ROW_ITEM, 2'd0, 16'h8000,   1'b0, 1'b1, 16'd2500},
        '{ROW_ITEM, 2'd0, 16'h7FFF,   1'b0, 1'b1, 16'd1250},
        '{ROW_ITEM, 2'd0, 16'd200,    1'b0, 1'b1, 16'd2500},
        '{ROW_ITEM, 2'd0, 16'd300,    1'b0, 1'b1, 16'd1250},
        '{ROW_ITEM, 2'd0, 16'd209,    1'b0, 1'b1, 16'd2500},
        '{ROW_ITEM, 2'd0, 16'(-9),    1'b0, 1'b1, 16'd2500},
        '{ROW_ITEM, 2'd0, 16'd250,    1'b0, 1'b0, 16'd0},
        '{ROW_ITEM, 2'd0, 16'd299,    1'b0, 1'b0, 16'd0},
        '{ROW_ITEM, 2'd0, 16'd211,    1'b0, 1'b0, 16'd0},
        '{ROW_ITEM, 2'd0, 16'd305,    1'b1, 1'b1, 16'd2500},
        // high limit below low limit
        '{ROW_CFG,  CFG_LOW_LIMIT,  16'd30, 1'b0, 1'b0, 16'd0},
        '{ROW_CFG,  CFG_HIGH_LIMIT, 16'd20, 1'b0, 1'b0, 16'd0},
        '{ROW_ITEM, 2'd0, 16'd250,    1'b0, 1'b1, 16'd2500},
        '{ROW_ITEM, 2'd0, 16'd310,    1'b0, 1'b1, 16'd1250},
        '{ROW_ITEM, 2'd0, 16'(-250),  1'b0, 1'b1, 16'd2500},
        // widest span, oversized limit data, unused index
        '{ROW_CFG,  CFG_TOP_COUNT,  16'hFFFF, 1'b0, 1'b0, 16'd0},
        '{ROW_CFG,  CFG_LOW_LIMIT,  16'hAB00, 1'b0, 1'b0, 16'd0},
        '{ROW_CFG,  CFG_HIGH_LIMIT, 16'h12FF, 1'b0, 1'b0, 16'd0},
        '{ROW_CFG,  CFG_UNUSED,     16'h0001, 1'b0, 1'b0, 16'd0},
        '{ROW_ITEM, 2'd0, 16'd1270,   1'b0, 1'b0, 16'd0},
        '{ROW_ITEM, 2'd0, 16'd2549,   1'b0, 1'b0, 16'd0},
        '{ROW_ITEM, 2'd0, 16'h7FFF,   1'b0, 1'b1, 16'd32767},
        '{ROW_ITEM, 2'd0, 16'hFFFF,   1'b0, 1'b1, 16'd65535},
        '{ROW_ITEM, 2'd0, 16'd0,      1'b1, 1'b1, 16'd65535},
        // smallest non-zero top count
        '{ROW_CFG,  CFG_TOP_COUNT,  16'd1, 1'b0, 1'b0, 16'd0},
        '{ROW_ITEM, 2'd0, 16'd1000,   1'b0, 1'b0, 16'd0},
        '{ROW_ITEM, 2'd0, 16'h7FFF,   1'b0, 1'b1, 16'd0},
        '{ROW_ITEM, 2'd0, 16'd0,      1'b0, 1'b1, 16'd1},
        // top count of zero
        '{ROW_CFG,  CFG_TOP_COUNT,  16'd0, 1'b0, 1'b0, 16'd0},
        '{ROW_ITEM, 2'd0, 16'd500,    1'b0, 1'b1, 16'd0},
        '{ROW_ITEM, 2'd0, 16'd0,      1'b1, 1'b1, 16'd0},
        // back to the reset top count with equal limits at the extreme
        '{ROW_CFG,  CFG_TOP_COUNT,  16'd2500, 1'b0, 1'b0, 16'd0},
        '{ROW_CFG,  CFG_LOW_LIMIT,  16'd255,  1'b0, 1'b0, 16'd0},
        '{ROW_ITEM, 2'd0, 16'd2550,   1'b0, 1'b1, 16'd1875},
        '{ROW_ITEM, 2'd0, 16'h8000,   1'b0, 1'b1, 16'd1875},
        '{ROW_ITEM, 2'd0, 16'd1234,   1'b1, 1'b1, 16'd2500}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_temp_tenths = '0;
    logic               i_out_of_range = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [15:0]        o_compare_value;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    logic [15:0] top_count_q = TOP_COUNT_RST;
    logic [7:0]  low_limit_q = '0;
    logic [7:0]  high_limit_q = '0;

    logic [15:0] expected_compare [$];
    int          mismatch_count = 0;
    bit          gapless = 1'b0;
    bit          long_hold_req = 1'b0;

    temperature_to_pwm_compare_map dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_temp_tenths   (i_temp_tenths),
        .i_out_of_range  (i_out_of_range),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_compare_value (o_compare_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [15:0] pwm_compare_for(logic signed [15:0] temp, logic alarm);
        int deg;
        int top;
        int half;
        int lo;
        int hi;
        deg = int'(temp) / 10;
        top = int'(top_count_q);
        half = top / 2;
        lo = int'(low_limit_q);
        hi = int'(high_limit_q);
        if (alarm) begin
            return 16'(top);
        end
        if (hi == lo) begin
            return 16'((top + half) / 2);
        end
        if (deg <= lo) begin
            return 16'(top);
        end
        if (deg >= hi) begin
            return 16'(half);
        end
        return 16'(top - ((top - half) * (deg - lo)) / (hi - lo));
    endfunction

    function automatic logic [15:0] random_temp();
        int sel;
        int span_lo;
        int span_hi;
        int deg;
        int frac;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            span_lo = ((low_limit_q < high_limit_q) ? int'(low_limit_q) : int'(high_limit_q)) - 4;
            span_hi = ((low_limit_q > high_limit_q) ? int'(low_limit_q) : int'(high_limit_q)) + 4;
            deg = span_lo + int'($urandom_range(0, span_hi - span_lo));
            frac = $urandom_range(0, 9);
            if (deg < 0 || (deg == 0 && $urandom_range(0, 1) == 1)) begin
                return 16'(deg * 10 - frac);
            end
            return 16'(deg * 10 + frac);
        end
        if (sel < 9) begin
            return 16'($urandom);
        end
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    task automatic report_error(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    // each call starts and ends just after a falling edge
    task automatic send_item(logic [15:0] temp, logic alarm, logic has_value,
                             logic [15:0] value);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_temp_tenths <= temp;
        i_out_of_range <= alarm;
        do @(posedge i_clk); while (o_in_stall);
        expected_compare.push_back(has_value ? value : pwm_compare_for(temp, alarm));
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_TOP_COUNT:  top_count_q = data;
            CFG_LOW_LIMIT:  low_limit_q = data[7:0];
            CFG_HIGH_LIMIT: high_limit_q = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (expected_compare.size() > 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_config();
        logic [15:0] top;
        logic [7:0]  lo;
        logic [7:0]  hi;
        case ($urandom_range(0, 9))
            0: top = 16'd1;
            1: top = 16'hFFFF;
            2: top = 16'd0;
            3: top = TOP_COUNT_RST;
            default: top = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: lo = 8'd0;
            1: lo = 8'd255;
            default: lo = 8'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: hi = lo;
            1: hi = 8'd255;
            2: hi = 8'd0;
            default: hi = 8'($urandom);
        endcase
        write_reg(CFG_TOP_COUNT, top);
        write_reg(CFG_LOW_LIMIT, {8'($urandom), lo});
        write_reg(CFG_HIGH_LIMIT, {8'($urandom), hi});
        if ($urandom_range(0, 1) == 1) begin
            write_reg(CFG_UNUSED, 16'($urandom));
        end
    endtask

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_compare.size() == 0) begin
                report_error($sformatf("unexpected compare value %0d", o_compare_value));
            end else begin
                if (o_compare_value !== expected_compare[0]) begin
                    report_error($sformatf("compare value expected %0d actual %0d",
                                           expected_compare[0], o_compare_value));
                end
                void'(expected_compare.pop_front());
            end
        end
    end

    // result side back-pressure
    initial begin
        int hold;
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD_CYCLES;
            end else begin
                hold = gapless ? 0 : $urandom_range(0, 15);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid));
            @(negedge i_clk);
        end
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
                drain_results();
                write_reg(DIRECTED_ROWS[r].index, DIRECTED_ROWS[r].data);
            end else begin
                send_item(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].alarm,
                          DIRECTED_ROWS[r].has_value, DIRECTED_ROWS[r].value);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            random_config();
            gapless = (p == 2 || p == 5);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // long output hold so the queue fills and the input stalls
                if (p == 3 && k == 40) begin
                    long_hold_req = 1'b1;
                end
                send_item(random_temp(), ($urandom_range(0, 9) == 0), 1'b0, 16'd0);
            end
        end
        gapless = 1'b0;

        drain_results();
        if (expected_compare.size() != 0) begin
            report_error($sformatf("%0d compare values never arrived", expected_compare.size()));
        end
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
